[rtl/core/nscd_pkg.sv]
// ----------------------------------------------------------------------------
// nscd_pkg
// Types and constants shared by the start code deframer: the input and
// result item layouts, the end-of-unit codes and the special stream bytes.
// ----------------------------------------------------------------------------
`default_nettype none

package nscd_pkg;

  localparam int LEN_W     = 21;
  localparam int OFF_OUT_W = 32;
  localparam int LEN_FIELD_MAX = (1 << LEN_W) - 1;

  localparam logic [7:0] BYTE_ZERO  = 8'h00;
  localparam logic [7:0] BYTE_START = 8'h01;
  localparam logic [7:0] BYTE_ESC   = 8'h03;

  typedef enum logic [1:0] {
    END_START = 2'd0,
    END_STOP  = 2'd1,
    END_EOS   = 2'd2
  } end_kind_t;

  typedef struct packed {
    logic [7:0] stream_byte;
    logic       stream_end;
  } in_item_t;

  typedef struct packed {
    logic [7:0]           payload_byte;
    logic                 byte_valid;
    logic                 unit_first;
    logic                 unit_last;
    logic [OFF_OUT_W-1:0] start_offset;
    logic [LEN_W-1:0]     payload_length;
    end_kind_t            end_kind;
    logic                 run_last;
  } out_item_t;

endpackage

`default_nettype wire

[rtl/core/nal_start_code_deframer_top.sv]
// ----------------------------------------------------------------------------
// nal_start_code_deframer_top
// Splits an Annex B byte stream into units: finds start codes, trims held
// zeros before start codes and stop patterns, tags first/last results.
// ----------------------------------------------------------------------------
// Output: the first result of an item appears in the cycle after it is taken.
// Throughput: one item per cycle while each item yields at most one result
//   and out_stall is low. An item that yields several results (up to 4) holds
//   the result buffer until they drain, and the input is stalled meanwhile.
// Reset: synchronous, active low; clears the parser state and empties the
//   result buffer. The stream offset restarts at 0.
`default_nettype none

module nal_start_code_deframer_top
  import nscd_pkg::*;
#(
  parameter int MAX_UNIT_BYTES = 1048576,
  parameter int OFFSET_BITS    = 32
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire in_item_t  in_data,
  output logic           out_valid,
  input  wire logic      out_stall,
  output out_item_t      out_data
);

  // Length saturates at the smaller of the unit limit and the field maximum.
  localparam int LEN_CAP_I = (MAX_UNIT_BYTES > LEN_FIELD_MAX) ? LEN_FIELD_MAX
                                                             : MAX_UNIT_BYTES;
  localparam logic [LEN_W-1:0] LEN_CAP = LEN_CAP_I[LEN_W-1:0];
  localparam int MAX_RES = 4;

  // --------------------------------------------------------------------------
  // Parser state
  // --------------------------------------------------------------------------
  logic [1:0]             zero_run_r,   zero_run_nxt;
  logic                   inside_r,     inside_nxt;
  logic                   skip_r,       skip_nxt;
  logic [7:0]             held_byte_r,  held_byte_nxt;
  logic                   held_valid_r, held_valid_nxt;
  logic                   first_r,      first_nxt;
  logic [OFFSET_BITS-1:0] pos_r,        pos_nxt;
  logic [OFFSET_BITS-1:0] ustart_r,     ustart_nxt;
  logic [LEN_W-1:0]       len_r,        len_nxt;

  // Results of the item in front of the buffer
  out_item_t  res     [MAX_RES];
  logic [2:0] res_cnt;

  // --------------------------------------------------------------------------
  // Result buffer: holds all results of one item and, while out_stall is low, drains one per cycle
  // --------------------------------------------------------------------------
  out_item_t  buf_r [MAX_RES];
  logic [2:0] rem_r;
  logic [1:0] idx_r;
  logic       take;
  logic       accept;

  assign out_valid = (rem_r != 3'd0);
  assign out_data  = buf_r[idx_r];
  assign take      = out_valid && !out_stall;
  // Accept when the buffer is empty or its last result leaves this cycle.
  assign in_stall  = !((rem_r == 3'd0) || (take && rem_r == 3'd1));
  assign accept    = in_valid && !in_stall;

  // --------------------------------------------------------------------------
  // One item: decide the branch, then play out end / open / pushes / end
  // --------------------------------------------------------------------------
  always_comb begin
    logic [7:0]             b;
    logic                   fin;
    logic                   end_a;
    end_kind_t              kind_a;
    logic                   open_u;
    logic [1:0]             k1;
    logic                   push_b;
    logic [1:0]             k2;
    logic                   end_b;
    logic [1:0]             npush;
    logic [1:0]             zr;
    logic                   ins;
    logic                   skp;
    logic [7:0]             hb;
    logic                   hv;
    logic                   fp;
    logic [OFFSET_BITS-1:0] ust;
    logic [LEN_W-1:0]       len;
    logic [2:0]             n;

    b   = in_data.stream_byte;
    fin = in_data.stream_end;

    zr  = zero_run_r;
    ins = inside_r;
    skp = skip_r;
    hb  = held_byte_r;
    hv  = held_valid_r;
    fp  = first_r;
    ust = ustart_r;
    len = len_r;

    end_a  = 1'b0;
    kind_a = END_START;
    open_u = 1'b0;
    k1     = 2'd0;
    push_b = 1'b0;
    k2     = 2'd0;
    end_b  = 1'b0;
    n      = 3'd0;

    for (int j = 0; j < MAX_RES; j++) begin
      res[j] = '0;
    end

    // Branch decision on the current byte
    if (!ins) begin
      if (skp) begin
        skp = 1'b0;
        zr  = 2'd0;
      end else if (b == BYTE_START && zr >= 2'd2) begin
        open_u = 1'b1;
      end else if (b == BYTE_ESC && zr >= 2'd2) begin
        skp = 1'b1;
        zr  = 2'd0;
      end else if (b == BYTE_ZERO) begin
        if (zr != 2'd3) zr = zr + 2'd1;
      end else begin
        zr = 2'd0;
      end
    end else begin
      if (skp) begin
        skp    = 1'b0;
        push_b = 1'b1;
        zr     = 2'd0;
      end else if (b == BYTE_START && zr >= 2'd2) begin
        end_a  = 1'b1;
        kind_a = END_START;
        open_u = 1'b1;
      end else if (b == BYTE_ESC && zr >= 2'd2) begin
        k1     = zr;
        push_b = 1'b1;
        zr     = 2'd0;
        skp    = 1'b1;
      end else if (b == BYTE_ZERO && zr >= 2'd2) begin
        end_a  = 1'b1;
        kind_a = END_STOP;
        ins    = 1'b0;
        zr     = 2'd3;
      end else if (b == BYTE_ZERO) begin
        zr = zr + 2'd1;
      end else begin
        k1     = zr;
        push_b = 1'b1;
        zr     = 2'd0;
      end
    end

    // Close a unit at end of stream, flushing its held zeros first
    if (open_u) begin
      ins = 1'b1;
    end
    if (fin && ins) begin
      k2    = open_u ? 2'd0 : zr;
      end_b = 1'b1;
    end
    npush = k1 + k2 + {1'b0, push_b};

    // End of the running unit before a start code or a stop pattern
    if (end_a) begin
      res[n[1:0]].payload_byte   = hv ? hb : 8'h00;
      res[n[1:0]].byte_valid     = hv;
      res[n[1:0]].unit_first     = fp;
      res[n[1:0]].unit_last      = 1'b1;
      res[n[1:0]].start_offset   = OFF_OUT_W'(ust);
      res[n[1:0]].payload_length = len;
      res[n[1:0]].end_kind       = kind_a;
      n   = n + 3'd1;
      fp  = 1'b0;
      hv  = 1'b0;
      hb  = 8'h00;
      len = '0;
    end

    // Open a unit at the first counted zero of its start code
    if (open_u) begin
      ust = pos_r - OFFSET_BITS'(zero_run_r);
      zr  = 2'd0;
      fp  = 1'b1;
      hv  = 1'b0;
      hb  = 8'h00;
      len = '0;
    end

    // Payload pushes: zeros, then the byte itself at place k1
    for (int j = 0; j < 3; j++) begin
      if (2'(j) < npush) begin
        if (hv) begin
          res[n[1:0]].payload_byte = hb;
          res[n[1:0]].byte_valid   = 1'b1;
          res[n[1:0]].unit_first   = fp;
          res[n[1:0]].start_offset = OFF_OUT_W'(ust);
          n  = n + 3'd1;
          fp = 1'b0;
        end
        hb = (push_b && 2'(j) == k1) ? b : 8'h00;
        hv = 1'b1;
        if (len < LEN_CAP) len = len + LEN_W'(1);
      end
    end

    // End of stream closes the unit
    if (end_b) begin
      res[n[1:0]].payload_byte   = hv ? hb : 8'h00;
      res[n[1:0]].byte_valid     = hv;
      res[n[1:0]].unit_first     = fp;
      res[n[1:0]].unit_last      = 1'b1;
      res[n[1:0]].start_offset   = OFF_OUT_W'(ust);
      res[n[1:0]].payload_length = len;
      res[n[1:0]].end_kind       = END_EOS;
      n = n + 3'd1;
    end

    // Mark the last result of this item
    for (int j = 0; j < MAX_RES; j++) begin
      res[j].run_last = ((3'(j) + 3'd1) == n);
    end
    res_cnt = n;

    // Next state; end of stream returns everything to reset values
    if (fin) begin
      zero_run_nxt   = 2'd0;
      inside_nxt     = 1'b0;
      skip_nxt       = 1'b0;
      held_byte_nxt  = 8'h00;
      held_valid_nxt = 1'b0;
      first_nxt      = 1'b0;
      pos_nxt        = '0;
      ustart_nxt     = '0;
      len_nxt        = '0;
    end else begin
      zero_run_nxt   = zr;
      inside_nxt     = ins;
      skip_nxt       = skp;
      held_byte_nxt  = hb;
      held_valid_nxt = hv;
      first_nxt      = fp;
      pos_nxt        = pos_r + OFFSET_BITS'(1);
      ustart_nxt     = ust;
      len_nxt        = len;
    end
  end

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      zero_run_r   <= 2'd0;
      inside_r     <= 1'b0;
      skip_r       <= 1'b0;
      held_byte_r  <= 8'h00;
      held_valid_r <= 1'b0;
      first_r      <= 1'b0;
      pos_r        <= '0;
      ustart_r     <= '0;
      len_r        <= '0;
      rem_r        <= 3'd0;
      idx_r        <= 2'd0;
    end else if (accept) begin
      // Advance the parser and load the whole burst of results
      zero_run_r   <= zero_run_nxt;
      inside_r     <= inside_nxt;
      skip_r       <= skip_nxt;
      held_byte_r  <= held_byte_nxt;
      held_valid_r <= held_valid_nxt;
      first_r      <= first_nxt;
      pos_r        <= pos_nxt;
      ustart_r     <= ustart_nxt;
      len_r        <= len_nxt;
      rem_r        <= res_cnt;
      idx_r        <= 2'd0;
    end else if (take) begin
      // Drop the taken result, present the next one
      rem_r <= rem_r - 3'd1;
      idx_r <= idx_r + 2'd1;
    end
  end

  // Result payload needs no reset
  always_ff @(posedge clk) begin
    if (accept) begin
      for (int j = 0; j < MAX_RES; j++) begin
        buf_r[j] <= res[j];
      end
    end
  end

endmodule

`default_nettype wire
